### design/grg_pkg.sv
// Shared types and constants of the Givens rotation generator.
// No dependencies; imported by every module of the block.
package grg_pkg;

   // Codes carried on the request tuser field
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_LEFT  = 2'd1;
   localparam logic [1:0] ACT_RIGHT = 2'd2;

   localparam int          REQ_DATA_W = 40;
   localparam int          RSP_DATA_W = 72;
   localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
   localparam logic [4:0]  LENGTH_RST = 5'd16;

   // One classified rotation request with its two operands
   typedef struct packed {
      logic        ok;
      logic        right;
      logic [3:0]  first_index;
      logic [3:0]  second_index;
      logic [31:0] a;
      logic [31:0] b;
   } entry_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_RD_A,
      FR_RD_B
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQ_A,
      BK_SQ_B,
      BK_SQ_SUM,
      BK_ROOT,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

### design/givens_rotation_generator.sv
// Givens rotation generator, top level. Instantiates grg_front, grg_queue
// and grg_back; depends on grg_pkg.
//
// A rotation request passes through the back end in order: squaring of both
// operands through one shared 32x32 multiplier, one sum, the bit-serial
// square root and the two restoring dividers, which run side by side; an
// out-of-range request or a zero norm skips the later steps. The front end
// takes no new transfer while it reads both operands of a request from the
// single-port element store; it takes an element write while idle and feeds
// a two-entry queue, so writes and the next requests are taken while the
// back end is busy. A result sits in an output register until its transfer,
// and the back end holds while that register is occupied. The element store
// clears on reset through one valid flag per entry, with no clearing pass.
// The length register may be written only while no request is in flight.
module givens_rotation_generator #(
   parameter int MAX_LENGTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // action
   input  logic [39:0] req_tdata,  // element_index, element_value, zero_index
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,  // ok
   output logic [71:0] rsp_tdata,  // first_index, second_index, cosine,
                                   // entry_first_second
   // length register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import grg_pkg::*;

   logic [4:0] vector_length_ff;
   logic       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   entry_type  q_in_entry, q_out_entry;

   // The register write is always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= LENGTH_RST;
      end else if (csr_valid) begin
         vector_length_ff <= csr_data;
      end
   end

   // Decode, element writes and operand fetch
   grg_front #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .vector_length (vector_length_ff),
      .push_valid    (q_in_valid),
      .push_ready    (q_in_ready),
      .push_entry    (q_in_entry)
   );

   // Decouple fetch from the arithmetic
   grg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_entry  (q_in_entry),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_entry (q_out_entry)
   );

   // Norm, root, quotients and result register
   grg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_out_valid),
      .pop_ready  (q_out_ready),
      .pop_entry  (q_out_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // A rejected index carries all-zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 72'd0)
      else $error("rejected rotation with nonzero fields");

   // Cosine never exceeds one in magnitude
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ($signed(rsp_tdata[39:8]) <= $signed(Q30_ONE)) &&
         ($signed(rsp_tdata[39:8]) >= -$signed(Q30_ONE)))
      else $error("cosine out of range");

   // The front end holds a push until the queue has room
   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      q_in_valid && !q_in_ready |=> q_in_valid && $stable(q_in_entry))
      else $error("front end dropped a queued entry");

endmodule

### design/grg_front.sv
// Front end: accepts request transfers, writes the element store, classifies
// rotation requests and fetches both operands. Depends on grg_pkg.
module grg_front #(
   parameter int MAX_LENGTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,
   input  logic [39:0]         req_tdata,
   input  logic [4:0]          vector_length,
   output logic                push_valid,
   input  logic                push_ready,
   output grg_pkg::entry_type  push_entry
);
   import grg_pkg::*;

   localparam int IW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int DEPTH = 1 << IW;

   front_state_type state_ff, state_in;

   logic [31:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]    rd_ff;
   logic           rdv_ff;
   logic [IW-1:0]  rd_addr;

   logic           ok_ff, right_ff;
   logic [7:0]     i_ff;
   logic [3:0]     j_ff;
   logic [31:0]    a_ff;

   logic [3:0]     widx, z;
   logic [31:0]    wval;
   logic [7:0]     vl8, max8, len8, z8, i8;
   logic           ok_c, accept, is_rot, do_write;

   assign widx = req_tdata[3:0];
   assign wval = req_tdata[35:4];
   assign z    = req_tdata[39:36];

   // Clamp length and pick the partner element
   always_comb begin
      vl8  = {3'b000, vector_length};
      max8 = 8'(MAX_LENGTH);
      z8   = {4'b0000, z};
      if (vl8 < 8'd2) begin
         len8 = 8'd2;
      end else if (vl8 > max8) begin
         len8 = max8;
      end else begin
         len8 = vl8;
      end
      ok_c = z8 < len8;
      if (req_tuser == ACT_LEFT) begin
         i8 = (z8 == 8'd0) ? len8 - 8'd1 : z8 - 8'd1;
      end else begin
         i8 = (z8 == len8 - 8'd1) ? 8'd0 : z8 + 8'd1;
      end
   end

   always_comb begin
      req_tready = (state_ff == FR_IDLE);
      push_valid = (state_ff == FR_RD_B);
      rd_addr    = (state_ff == FR_IDLE) ? IW'(i8) : IW'(j_ff);
      push_entry.ok           = ok_ff;
      push_entry.right        = right_ff;
      push_entry.first_index  = i_ff[3:0];
      push_entry.second_index = j_ff;
      push_entry.a            = a_ff;
      push_entry.b            = rdv_ff ? rd_ff : 32'd0;
   end

   assign accept   = req_tvalid && req_tready;
   assign is_rot   = (req_tuser == ACT_LEFT) || (req_tuser == ACT_RIGHT);
   assign do_write = accept && (req_tuser == ACT_WRITE) &&
                     ({4'b0000, widx} < 8'(MAX_LENGTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept && is_rot) state_in = FR_RD_A;
         end
         FR_RD_A: state_in = FR_RD_B;
         FR_RD_B: begin
            if (push_ready) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (do_write) valid_ff[IW'(widx)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[IW'(widx)] <= wval;
      rd_ff  <= mem[rd_addr];
      rdv_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && is_rot) begin
         ok_ff    <= ok_c;
         right_ff <= (req_tuser == ACT_RIGHT);
         i_ff     <= ok_c ? i8 : 8'd0;
         j_ff     <= ok_c ? z : 4'd0;
      end
      if (state_ff == FR_RD_A) a_ff <= rdv_ff ? rd_ff : 32'd0;
   end

endmodule

### design/grg_queue.sv
// Two-entry queue between front and back end.
// Depends on grg_pkg for the entry type.
module grg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  grg_pkg::entry_type in_entry,
   output logic               out_valid,
   input  logic               out_ready,
   output grg_pkg::entry_type out_entry
);
   import grg_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_entry;
   end

endmodule

### design/grg_back.sv
// Back end: squared norm, bit-serial integer square root and two radix-2
// restoring dividers, then the result register. Depends on grg_pkg.
module grg_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  grg_pkg::entry_type         pop_entry,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_tuser,
   output logic [grg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import grg_pkg::*;

   back_state_type state_ff, state_in;

   logic        ok_ff, right_ff, neg_a_ff, neg_b_ff, zero_ff;
   logic [3:0]  first_ff, second_ff;
   logic [31:0] mag_a_ff, mag_b_ff, r_ff;
   logic [63:0] sq_ff, prod_ff, res_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic [33:0] rem_a_ff, rem_b_ff;
   logic [30:0] qa_ff, qb_ff;

   logic        out_valid_ff, out_ok_ff;
   logic [71:0] out_data_ff;

   logic [31:0] mul_op, mag_a_c, mag_b_c;
   logic [63:0] prod, root_t, res_nx, sq_nx;
   logic [33:0] ta, tb;
   logic [31:0] cos_c, sin_c;
   logic        neg_s, load_out;

   assign mag_a_c = pop_entry.a[31] ? 32'(-pop_entry.a) : pop_entry.a;
   assign mag_b_c = pop_entry.b[31] ? 32'(-pop_entry.b) : pop_entry.b;
   assign prod    = mul_op * mul_op;

   // One root step per cycle
   always_comb begin
      root_t = res_ff + bit_ff;
      if (sq_ff >= root_t) begin
         sq_nx  = sq_ff - root_t;
         res_nx = (res_ff >> 1) + bit_ff;
      end else begin
         sq_nx  = sq_ff;
         res_nx = res_ff >> 1;
      end
      ta = (cnt_ff == 5'd30) ? rem_a_ff : {rem_a_ff[32:0], 1'b0};
      tb = (cnt_ff == 5'd30) ? rem_b_ff : {rem_b_ff[32:0], 1'b0};
   end

   always_comb begin
      neg_s = neg_b_ff ^ right_ff;
      if (!ok_ff) begin
         cos_c = 32'd0;
         sin_c = 32'd0;
      end else if (zero_ff) begin
         cos_c = Q30_ONE;
         sin_c = 32'd0;
      end else begin
         cos_c = neg_a_ff ? 32'(-{1'b0, qa_ff}) : {1'b0, qa_ff};
         sin_c = neg_s ? 32'(-{1'b0, qb_ff}) : {1'b0, qb_ff};
      end
   end

   always_comb begin
      pop_ready = (state_ff == BK_IDLE);
      mul_op    = (state_ff == BK_SQ_A) ? mag_a_ff : mag_b_ff;
      load_out  = (state_ff == BK_DONE) && (!out_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) state_in = pop_entry.ok ? BK_SQ_A : BK_DONE;
         end
         BK_SQ_A:   state_in = BK_SQ_B;
         BK_SQ_B:   state_in = BK_SQ_SUM;
         BK_SQ_SUM: state_in = BK_ROOT;
         BK_ROOT: begin
            if (cnt_ff == 5'd0) state_in = (res_nx == 64'd0) ? BK_DONE : BK_DIV;
         end
         BK_DIV: begin
            if (cnt_ff == 5'd0) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (load_out) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               ok_ff     <= pop_entry.ok;
               right_ff  <= pop_entry.right;
               first_ff  <= pop_entry.first_index;
               second_ff <= pop_entry.second_index;
               neg_a_ff  <= pop_entry.a[31];
               neg_b_ff  <= pop_entry.b[31];
               mag_a_ff  <= mag_a_c;
               mag_b_ff  <= mag_b_c;
               zero_ff   <= 1'b0;
            end
         end
         BK_SQ_A: sq_ff <= prod;
         BK_SQ_B: prod_ff <= prod;
         BK_SQ_SUM: begin
            sq_ff  <= sq_ff + prod_ff;
            res_ff <= 64'd0;
            bit_ff <= 64'd1 << 62;
            cnt_ff <= 5'd31;
         end
         BK_ROOT: begin
            sq_ff  <= sq_nx;
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               zero_ff  <= (res_nx == 64'd0);
               r_ff     <= res_nx[31:0];
               rem_a_ff <= {2'b00, mag_a_ff};
               rem_b_ff <= {2'b00, mag_b_ff};
               qa_ff    <= 31'd0;
               qb_ff    <= 31'd0;
               cnt_ff   <= 5'd30;
            end
         end
         BK_DIV: begin
            if (ta >= {2'b00, r_ff}) begin
               rem_a_ff <= ta - {2'b00, r_ff};
               qa_ff    <= {qa_ff[29:0], 1'b1};
            end else begin
               rem_a_ff <= ta;
               qa_ff    <= {qa_ff[29:0], 1'b0};
            end
            if (tb >= {2'b00, r_ff}) begin
               rem_b_ff <= tb - {2'b00, r_ff};
               qb_ff    <= {qb_ff[29:0], 1'b1};
            end else begin
               rem_b_ff <= tb;
               qb_ff    <= {qb_ff[29:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
      if (load_out) begin
         out_ok_ff   <= ok_ff;
         out_data_ff <= {sin_c, cos_c, second_ff, first_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### verif/tb_givens_rotation_generator.sv
// Self-checking testbench for givens_rotation_generator: drives element writes and
// rotation requests, predicts each rotation result and compares field by field.
// Depends on grg_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_givens_rotation_generator;
   import grg_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 2000000;
   // settling time after the last result, with margin over one rotation
   localparam int DRAIN_CYCLES = 300;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [39:0] data;  // element_index, element_value, zero_index
   } req_item_t;

   typedef struct packed {
      logic        ok;
      logic [3:0]  first_index;
      logic [3:0]  second_index;
      logic [31:0] cosine;
      logic [31:0] entry_first_second;
   } rotation_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;

   givens_rotation_generator #(.MAX_LENGTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: a shadow of the element store and the length register
   logic [31:0] shadow_vec [DEPTH];
   logic [4:0]  shadow_len;

   req_item_t pending_reqs [$];
   rotation_t expected_rotations [$];
   int  errors = 0;
   int  cycle = 0;
   bit  calm = 1'b0;   // when set, neither side idles
   bit  csr_busy = 1'b0;

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Q2.30 quotient truncated toward zero
   function automatic logic [31:0] q30_ratio(logic signed [63:0] x, logic [63:0] r);
      logic [63:0] mag, q;
      mag = (x < 0) ? -x : x;
      q = (mag << 30) / r;
      return (x < 0) ? 32'(-q) : 32'(q);
   endfunction

   // Update the shadow store or compute the expected rotation; an unused action does neither
   function automatic void predict_rotation(req_item_t it);
      logic [3:0] widx, z;
      logic [4:0] len;
      logic [3:0] i;
      logic signed [63:0] a, b;
      logic [63:0] r;
      rotation_t rot;
      widx = it.data[3:0];
      z = it.data[39:36];
      if (it.action == ACT_WRITE) begin
         shadow_vec[widx] = it.data[35:4];
         return;
      end
      if (it.action == ACT_NONE) return;
      len = shadow_len < 2 ? 5'd2 : (shadow_len > DEPTH ? 5'(DEPTH) : shadow_len);
      rot = '0;
      if (z < len) begin
         if (it.action == ACT_LEFT) i = (z == 0) ? 4'(len - 1) : z - 1;
         else i = (5'(z) == len - 1) ? 4'd0 : z + 1;
         a = $signed(shadow_vec[i]);
         b = $signed(shadow_vec[z]);
         r = root64(64'(a * a) + 64'(b * b));
         rot.ok = 1'b1;
         rot.first_index = i;
         rot.second_index = z;
         if (r == 0) begin
            rot.cosine = Q30_ONE;
         end else begin
            rot.cosine = q30_ratio(a, r);
            rot.entry_first_second = q30_ratio(b, r);
         end
         if (it.action == ACT_RIGHT) rot.entry_first_second = -rot.entry_first_second;
      end
      expected_rotations.push_back(rot);
   endfunction

   // Request driver: present the head of the queue, drop it on its transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_rotation({req_tuser, req_tdata});
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
            req_tvalid <= 1'b1;
            {req_tuser, req_tdata} <= pending_reqs[0];
         end else if (!(req_tvalid && !req_tready)) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      rotation_t got, want;
      if (!reset) begin
         rsp_tready <= calm || ($urandom_range(99) >= 11);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[39:8],
                   rsp_tdata[71:40]};
            if (expected_rotations.size() == 0) begin
               $error("unexpected rotation result %h", got);
               errors++;
            end else begin
               want = expected_rotations.pop_front();
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok); errors++;
               end
               if (got.first_index !== want.first_index) begin
                  $error("first_index: expected %0d, got %0d",
                         want.first_index, got.first_index); errors++;
               end
               if (got.second_index !== want.second_index) begin
                  $error("second_index: expected %0d, got %0d",
                         want.second_index, got.second_index); errors++;
               end
               if (got.cosine !== want.cosine) begin
                  $error("cosine: expected %h, got %h", want.cosine, got.cosine); errors++;
               end
               if (got.entry_first_second !== want.entry_first_second) begin
                  $error("entry_first_second: expected %h, got %h",
                         want.entry_first_second, got.entry_first_second); errors++;
               end
            end
         end
      end
   end

   // Length register writes, one transfer at a time
   always @(posedge clock) begin
      if (csr_valid && csr_ready) begin
         shadow_len = csr_data;
         csr_valid <= 1'b0;
         csr_busy = 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
         $display("tb_givens_rotation_generator: FAIL");
         $finish;
      end
   end

   function automatic req_item_t make_write(logic [3:0] idx, logic [31:0] v);
      return {ACT_WRITE, 4'd0, v, idx};
   endfunction

   function automatic req_item_t make_rot(logic [1:0] act, logic [3:0] z);
      return {act, z, $urandom(), 4'($urandom_range(15))};
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'($signed($urandom_range(200)) - 100);
         default: return $urandom();
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rotations.size() != 0)
         @(posedge clock);
      // a trailing write causes no result; let the pipeline settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [4:0] len);
      @(posedge clock);
      csr_data <= len;
      csr_valid <= 1'b1;
      csr_busy = 1'b1;
      while (csr_busy) @(posedge clock);
   endtask

   // Random phase: a random mix of element writes, rotations at any index and unused actions
   task automatic random_phase(int count);
      int k;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: pending_reqs.push_back(make_write(4'($urandom_range(15)),
                                                          rand_value()));
            4, 5, 6: pending_reqs.push_back(make_rot(ACT_LEFT, 4'($urandom_range(15))));
            7, 8: pending_reqs.push_back(make_rot(ACT_RIGHT, 4'($urandom_range(15))));
            default: pending_reqs.push_back({ACT_NONE, 40'($urandom()) ^ 40'($urandom()) << 8});
         endcase
      end
   endtask

   initial begin
      logic [4:0] lengths [6];
      int p;
      lengths = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd1};
      foreach (shadow_vec[k]) shadow_vec[k] = '0;
      shadow_len = LENGTH_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero norm after reset, extremes, wraps, out-of-range, unused action
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd0));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd15));
      pending_reqs.push_back(make_write(4'd0, 32'h8000_0000));
      pending_reqs.push_back(make_write(4'd15, 32'h8000_0000));
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd0));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd15));
      pending_reqs.push_back(make_write(4'd1, 32'h7fff_ffff));
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd1));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd0));
      pending_reqs.push_back(make_write(4'd2, 32'hffff_ffff));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd1));
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd2));
      pending_reqs.push_back({ACT_NONE, 40'hff_ffff_ffff});
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd3));
      wait_idle();
      write_length(5'd2);
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd2));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd15));
      pending_reqs.push_back(make_rot(ACT_LEFT, 4'd0));
      pending_reqs.push_back(make_rot(ACT_RIGHT, 4'd1));
      wait_idle();

      // Random phases across length settings; the third one runs without idling
      for (p = 0; p < 6; p++) begin
         write_length(lengths[p]);
         calm = (p == 2);
         random_phase(165);
         wait_idle();
      end
      calm = 1'b0;

      if (errors == 0) begin
         $display("tb_givens_rotation_generator: PASS");
      end else begin
         $display("tb_givens_rotation_generator: FAIL");
      end
      $finish;
   end
endmodule
